>>> rtl/pcm_to_stereo_s16_converter_defines.svh
// Assertion macros used by the converter back end
`ifndef PCM_TO_STEREO_S16_CONVERTER_DEFINES_SVH
`define PCM_TO_STEREO_S16_CONVERTER_DEFINES_SVH

// Implication that must hold on every clock edge outside reset
`define P2S_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication outside reset
`define P2S_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

>>> rtl/p2s_pkg.sv
// Shared types and constants for the PCM to stereo converter
package p2s_pkg;

   // Input sample encodings
   localparam logic FMT_S16 = 1'b0;
   localparam logic FMT_F32 = 1'b1;

   // Input channel layouts
   typedef enum logic [1:0] {
      MODE_MONO   = 2'd0,
      MODE_STEREO = 2'd1,
      MODE_OCT    = 2'd2,
      MODE_NONE   = 2'd3
   } mode_type;

   // Configuration register indexes
   localparam logic CSR_FORMAT = 1'b0;
   localparam logic CSR_MODE   = 1'b1;

   // One classified command passed from front to back
   typedef struct packed {
      logic [15:0] sample;
      logic        slot;
      logic        dual;    // emit left then right
   } cmd_type;

endpackage

>>> rtl/pcm_to_stereo_s16_converter.sv
// Top level of the PCM to stereo s16 converter
// Accepts one sample per cycle when the two-entry command queue has room; a
// stereo item yields one result, an eight-channel item yields one result for
// each of its first two channels and none for the rest, and a mono item yields
// two results (left, then right) at the back end, read out of the queue.
module pcm_to_stereo_s16_converter (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [31:0] req_sample_word,
   input  logic        req_buffer_end,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic signed [15:0] rsp_out_sample,
   output logic        rsp_out_channel,
   output logic        rsp_run_end,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [1:0]  csr_wdata
);
   logic              fmt_ff;
   p2s_pkg::mode_type mode_ff;
   logic              take, emit;
   p2s_pkg::cmd_type  cmd;
   logic [15:0]       samp;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff <= p2s_pkg::FMT_S16; mode_ff <= p2s_pkg::MODE_STEREO;
      end else if (csr_we) begin
         if (csr_index == p2s_pkg::CSR_FORMAT) fmt_ff <= csr_wdata[0];
         else mode_ff <= p2s_pkg::mode_type'(csr_wdata);
      end
   end

   assign take = req_push && !req_full;

   p2s_front u_front (.clock, .reset, .take, .sample_word(req_sample_word),
      .buffer_end(req_buffer_end), .fmt(fmt_ff), .mode(mode_ff), .emit, .cmd);

   p2s_back u_back (.clock, .reset, .wr(emit), .cmd, .full(req_full),
      .empty(rsp_empty), .pop(rsp_pop), .sample(samp), .slot(rsp_out_channel),
      .last(rsp_run_end));

   assign rsp_out_sample = samp;
endmodule

>>> rtl/p2s_float_cvt.sv
// Float32 bit pattern to saturated, rounded s16
module p2s_float_cvt (
   input  logic [31:0] word,
   output logic [15:0] result
);
   logic        sign;
   logic [7:0]  expo;
   logic [22:0] frac;
   logic [4:0]  sh;      // weight of the mantissa lsb above 2^-25
   logic [25:0] t;       // |v*32768| + 0.5 in units of the mantissa lsb
   logic [25:0] tr;      // t rounded back to 24 significant bits
   logic [41:0] fixed;   // rounded sum with 25 fraction bits
   logic [16:0] mag;

   always_comb begin
      sign   = word[31];
      expo   = word[30:23];
      frac   = word[22:0];
      sh     = 5'd0;
      t      = '0;
      tr     = '0;
      fixed  = '0;
      mag    = '0;
      result = 16'd0;
      if (expo == 8'hFF) begin
         // NaN gives zero, infinity saturates
         if (frac != 23'd0) result = 16'd0;
         else result = sign ? 16'h8000 : 16'h7FFF;
      end else if (expo >= 8'd127) begin
         // |v*32768| >= 32768
         result = sign ? 16'h8000 : 16'h7FFF;
      end else if (expo >= 8'd110) begin
         // |v*32768| = mant * 2^(expo-135); smaller values round to zero
         sh = 5'(expo - 8'd110);   // 0..16
         t  = {3'b001, frac} + (26'd1 << (5'd24 - sh));
         // single-precision bias add: on a carry out of the mantissa the
         // lowest bit is dropped, rounded to nearest even
         tr = t;
         if (t[24] && t[0]) tr = t[1] ? t + 26'd1 : t - 26'd1;
         // truncate toward zero
         fixed = {16'd0, tr} << sh;
         mag   = fixed[41:25];
         if (!sign && mag >= 17'd32767) result = 16'h7FFF;
         else result = sign ? 16'(-mag) : mag[15:0];
      end
   end
endmodule

>>> rtl/p2s_front.sv
// Front end: converts and classifies each accepted item
module p2s_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              take,
   input  logic [31:0]       sample_word,
   input  logic              buffer_end,
   input  logic              fmt,
   input  p2s_pkg::mode_type mode,
   output logic              emit,
   output p2s_pkg::cmd_type  cmd
);
   localparam int unsigned MAX_CHANNELS = 8;
   logic [2:0] pos_ff, pos_in;
   logic [15:0] fsamp, samp;
   logic [2:0] p;

   p2s_float_cvt u_cvt (.word(sample_word), .result(fsamp));

   always_comb begin
      samp = (fmt == p2s_pkg::FMT_F32) ? fsamp : sample_word[15:0];
      emit = 1'b0;
      cmd.sample = samp;
      cmd.slot = 1'b0;
      cmd.dual = 1'b0;
      pos_in = pos_ff;
      p = pos_ff;
      case (mode)
         p2s_pkg::MODE_MONO: begin
            emit = 1'b1; cmd.dual = 1'b1; pos_in = 3'd0;
         end
         p2s_pkg::MODE_STEREO: begin
            emit = 1'b1; cmd.slot = pos_ff[0]; pos_in = {2'd0, ~pos_ff[0]};
         end
         p2s_pkg::MODE_OCT: begin
            emit = (p < 3'd2); cmd.slot = p[0];
            pos_in = (32'(p) + 1 >= MAX_CHANNELS) ? 3'd0 : p + 3'd1;
         end
         default: pos_in = 3'd0;
      endcase
      if (buffer_end) pos_in = 3'd0;
      if (!take) emit = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) pos_ff <= 3'd0;
      else if (take) pos_ff <= pos_in;
   end
endmodule

>>> rtl/p2s_back.sv
// Back end: command queue and result emission
`include "pcm_to_stereo_s16_converter_defines.svh"
module p2s_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr,
   input  p2s_pkg::cmd_type cmd,
   output logic             full,
   output logic             empty,
   input  logic             pop,
   output logic [15:0]      sample,
   output logic             slot,
   output logic             last
);
   p2s_pkg::cmd_type q_ff [2];
   logic       wp_ff, rp_ff, half_ff;
   logic [1:0] cnt_ff;
   logic       rd, done;

   assign empty = (cnt_ff == 2'd0);
   assign full  = (cnt_ff == 2'd2);
   assign sample = q_ff[rp_ff].sample;
   assign slot   = q_ff[rp_ff].dual ? half_ff : q_ff[rp_ff].slot;
   assign last   = !q_ff[rp_ff].dual || half_ff;
   assign rd     = pop && !empty;
   assign done   = rd && last;

   // queue pointers, count, and dual-result phase
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0; rp_ff <= 1'b0; cnt_ff <= 2'd0; half_ff <= 1'b0;
      end else begin
         if (wr) wp_ff <= ~wp_ff;
         if (done) rp_ff <= ~rp_ff;
         cnt_ff <= cnt_ff + {1'b0, wr} - {1'b0, done};
         if (rd) half_ff <= !last;
      end
   end

   always_ff @(posedge clock) begin
      if (wr) q_ff[wp_ff] <= cmd;
   end

   `P2S_ASSERT_IMPL(a_no_ovf, clock, reset, full, !wr)
   `P2S_ASSERT_IMPL(a_half_dual, clock, reset, half_ff, !empty && q_ff[rp_ff].dual)
   `P2S_ASSERT_NEXT(a_second, clock, reset, rd && !last, half_ff)
endmodule
